/* rtl/talb_pkg.sv */
// Package for the traffic activity LED blinker: widths, reset values,
// configuration register indexes, sequencer states and the half-period table.
// No dependencies.
`default_nettype none

package talb_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int COUNT_WIDTH      = 32;
    localparam int THR_WIDTH        = 18;
    localparam int RATE_WIDTH       = 6;
    localparam int HALF_WIDTH       = 10;
    localparam int HALVES_WIDTH     = 7;
    localparam int ITER_WIDTH       = $clog2(COUNT_WIDTH);

    localparam logic [THR_WIDTH-1:0]  THR_RESET  = THR_WIDTH'(8192);
    localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(10);

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_MAX_RATE  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_RATE,
        ST_DONE
    } state_t;

    // Ticks in one half of an off-on cycle, indexed by blink rate.
    localparam logic [HALF_WIDTH-1:0] HALF_TABLE [2**RATE_WIDTH] = '{
        HALF_WIDTH'(0),
        HALF_WIDTH'(TICKS_PER_SECOND / 2),   HALF_WIDTH'(TICKS_PER_SECOND / 4),
        HALF_WIDTH'(TICKS_PER_SECOND / 6),   HALF_WIDTH'(TICKS_PER_SECOND / 8),
        HALF_WIDTH'(TICKS_PER_SECOND / 10),  HALF_WIDTH'(TICKS_PER_SECOND / 12),
        HALF_WIDTH'(TICKS_PER_SECOND / 14),  HALF_WIDTH'(TICKS_PER_SECOND / 16),
        HALF_WIDTH'(TICKS_PER_SECOND / 18),  HALF_WIDTH'(TICKS_PER_SECOND / 20),
        HALF_WIDTH'(TICKS_PER_SECOND / 22),  HALF_WIDTH'(TICKS_PER_SECOND / 24),
        HALF_WIDTH'(TICKS_PER_SECOND / 26),  HALF_WIDTH'(TICKS_PER_SECOND / 28),
        HALF_WIDTH'(TICKS_PER_SECOND / 30),  HALF_WIDTH'(TICKS_PER_SECOND / 32),
        HALF_WIDTH'(TICKS_PER_SECOND / 34),  HALF_WIDTH'(TICKS_PER_SECOND / 36),
        HALF_WIDTH'(TICKS_PER_SECOND / 38),  HALF_WIDTH'(TICKS_PER_SECOND / 40),
        HALF_WIDTH'(TICKS_PER_SECOND / 42),  HALF_WIDTH'(TICKS_PER_SECOND / 44),
        HALF_WIDTH'(TICKS_PER_SECOND / 46),  HALF_WIDTH'(TICKS_PER_SECOND / 48),
        HALF_WIDTH'(TICKS_PER_SECOND / 50),  HALF_WIDTH'(TICKS_PER_SECOND / 52),
        HALF_WIDTH'(TICKS_PER_SECOND / 54),  HALF_WIDTH'(TICKS_PER_SECOND / 56),
        HALF_WIDTH'(TICKS_PER_SECOND / 58),  HALF_WIDTH'(TICKS_PER_SECOND / 60),
        HALF_WIDTH'(TICKS_PER_SECOND / 62),  HALF_WIDTH'(TICKS_PER_SECOND / 64),
        HALF_WIDTH'(TICKS_PER_SECOND / 66),  HALF_WIDTH'(TICKS_PER_SECOND / 68),
        HALF_WIDTH'(TICKS_PER_SECOND / 70),  HALF_WIDTH'(TICKS_PER_SECOND / 72),
        HALF_WIDTH'(TICKS_PER_SECOND / 74),  HALF_WIDTH'(TICKS_PER_SECOND / 76),
        HALF_WIDTH'(TICKS_PER_SECOND / 78),  HALF_WIDTH'(TICKS_PER_SECOND / 80),
        HALF_WIDTH'(TICKS_PER_SECOND / 82),  HALF_WIDTH'(TICKS_PER_SECOND / 84),
        HALF_WIDTH'(TICKS_PER_SECOND / 86),  HALF_WIDTH'(TICKS_PER_SECOND / 88),
        HALF_WIDTH'(TICKS_PER_SECOND / 90),  HALF_WIDTH'(TICKS_PER_SECOND / 92),
        HALF_WIDTH'(TICKS_PER_SECOND / 94),  HALF_WIDTH'(TICKS_PER_SECOND / 96),
        HALF_WIDTH'(TICKS_PER_SECOND / 98),  HALF_WIDTH'(TICKS_PER_SECOND / 100),
        HALF_WIDTH'(TICKS_PER_SECOND / 102), HALF_WIDTH'(TICKS_PER_SECOND / 104),
        HALF_WIDTH'(TICKS_PER_SECOND / 106), HALF_WIDTH'(TICKS_PER_SECOND / 108),
        HALF_WIDTH'(TICKS_PER_SECOND / 110), HALF_WIDTH'(TICKS_PER_SECOND / 112),
        HALF_WIDTH'(TICKS_PER_SECOND / 114), HALF_WIDTH'(TICKS_PER_SECOND / 116),
        HALF_WIDTH'(TICKS_PER_SECOND / 118), HALF_WIDTH'(TICKS_PER_SECOND / 120),
        HALF_WIDTH'(TICKS_PER_SECOND / 122), HALF_WIDTH'(TICKS_PER_SECOND / 124),
        HALF_WIDTH'(TICKS_PER_SECOND / 126)
    };

endpackage

`default_nettype wire

/* rtl/traffic_activity_led_blinker_core.sv */
// Top level of the traffic activity LED blinker: sequencer, iterative
// restoring divider and burst timer. Depends on talb_pkg.
//
// Usage: the slave channel takes one item per transfer. tuser carries the
// opcode (sample or tick); tdata carries the byte count and the radio-off
// flag. Each item yields exactly one result transfer on the master channel
// with the LED level, whether a sample was taken, and whether a burst runs.
// Configuration (threshold, maximum rate) is a plain write port; the user
// must write it only while the block is idle, which the block does not enforce.
// A tick, or a sample that starts no division, goes through the eval and done
// states before m_tvalid rises. A sample taken while no burst runs, whose
// growth reaches a nonzero threshold, runs the 1-bit-per-cycle divider over
// all 32 growth bits, then the rate and done states. s_tready is high only in
// the idle state, so no new item is taken until the last one leaves the done
// state. The result register lets a new item be taken while the last result
// waits; if the receiver stalls, the next result holds in the done state until
// the register frees up. Reset (aresetn low, synchronous) clears the control
// state; the LED goes off and the configuration returns to 8192 bytes, rate 10.
`default_nettype none

module traffic_activity_led_blinker_core
    import talb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave: tdata = {pad[39:33], radio_off[32], byte_count[31:0]}
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [39:0]           s_tdata,
    // slave: tuser = {opcode[0]}
    input  wire logic                  s_tuser,
    // master: tdata = {pad[7:3], blinking[2], sample_accepted[1], led_on[0]}
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [THR_WIDTH-1:0]  cfg_wdata
);

    state_t                     state_reg, state_next;
    logic [THR_WIDTH-1:0]       thr_reg, thr_next;
    logic [RATE_WIDTH-1:0]      max_rate_reg, max_rate_next;

    logic                       op_reg, op_next;
    logic [COUNT_WIDTH-1:0]     count_reg, count_next;
    logic                       radio_off_reg, radio_off_next;
    logic                       taken_reg, taken_next;

    logic [COUNT_WIDTH-1:0]     prev_reg, prev_next;
    logic [HALF_WIDTH-1:0]      half_period_reg, half_period_next;
    logic [HALF_WIDTH-1:0]      countdown_reg, countdown_next;
    logic [HALVES_WIDTH-1:0]    halves_reg, halves_next;
    logic                       led_reg, led_next;

    logic [COUNT_WIDTH-1:0]     div_reg, div_next;
    logic [THR_WIDTH-1:0]       rem_reg, rem_next;
    logic [ITER_WIDTH-1:0]      iter_reg, iter_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [2:0]                 m_flags_reg, m_flags_next;

    logic [COUNT_WIDTH:0]       grow_ext;
    logic                       grow_enough;
    logic [THR_WIDTH:0]         trial;
    logic                       trial_fits;
    logic [THR_WIDTH:0]         trial_diff;
    logic [RATE_WIDTH-1:0]      capped_rate;
    logic                       start_go;
    logic [RATE_WIDTH-1:0]      start_rate;
    logic [HALF_WIDTH-1:0]      start_half;
    logic [HALVES_WIDTH-1:0]    halves_dec;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_flags_reg};

    // Growth since the last count that reached the threshold; the top bit is the borrow.
    assign grow_ext    = {1'b0, count_reg} - {1'b0, prev_reg};
    assign grow_enough = !grow_ext[COUNT_WIDTH]
                         && (grow_ext[COUNT_WIDTH-1:0] >= COUNT_WIDTH'(thr_reg));

    // One restoring divide step: shift in the next dividend bit, try subtract.
    assign trial      = {rem_reg, div_reg[COUNT_WIDTH-1]};
    assign trial_fits = (trial >= {1'b0, thr_reg});
    assign trial_diff = trial - {1'b0, thr_reg};

    assign capped_rate = (div_reg > COUNT_WIDTH'(max_rate_reg))
                         ? max_rate_reg : div_reg[RATE_WIDTH-1:0];

    assign start_half = (HALF_TABLE[start_rate] == '0)
                        ? HALF_WIDTH'(1) : HALF_TABLE[start_rate];
    assign halves_dec = halves_reg - HALVES_WIDTH'(1);

    always_comb begin
        state_next       = state_reg;
        thr_next         = thr_reg;
        max_rate_next    = max_rate_reg;
        op_next          = op_reg;
        count_next       = count_reg;
        radio_off_next   = radio_off_reg;
        taken_next       = taken_reg;
        prev_next        = prev_reg;
        half_period_next = half_period_reg;
        countdown_next   = countdown_reg;
        halves_next      = halves_reg;
        led_next         = led_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        iter_next        = iter_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_flags_next     = m_flags_reg;
        start_go         = 1'b0;
        start_rate       = capped_rate;

        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_THRESHOLD: thr_next      = cfg_wdata;
                CFG_MAX_RATE:  max_rate_next = cfg_wdata[RATE_WIDTH-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next        = s_tuser;
                    count_next     = s_tdata[COUNT_WIDTH-1:0];
                    radio_off_next = s_tdata[COUNT_WIDTH];
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                taken_next = 1'b0;
                state_next = ST_DONE;
                if (opcode_t'(op_reg) == OP_TICK) begin
                    if (halves_reg != '0) begin
                        if (countdown_reg > HALF_WIDTH'(1)) begin
                            countdown_next = countdown_reg - HALF_WIDTH'(1);
                        end else begin
                            halves_next    = halves_dec;
                            countdown_next = half_period_reg;
                            // stay lit after the last half
                            led_next       = (halves_dec == '0) || halves_dec[0];
                        end
                    end
                end else if (halves_reg == '0) begin
                    taken_next = 1'b1;
                    if (!grow_enough) begin
                        led_next = !radio_off_reg;
                    end else begin
                        prev_next = count_reg;
                        if (thr_reg == '0) begin
                            start_go   = 1'b1;
                            start_rate = max_rate_reg;
                        end else begin
                            div_next   = grow_ext[COUNT_WIDTH-1:0];
                            rem_next   = '0;
                            iter_next  = '0;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                rem_next  = trial_fits ? trial_diff[THR_WIDTH-1:0] : trial[THR_WIDTH-1:0];
                div_next  = {div_reg[COUNT_WIDTH-2:0], trial_fits};
                iter_next = iter_reg + ITER_WIDTH'(1);
                if (iter_reg == ITER_WIDTH'(COUNT_WIDTH - 1)) begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE: begin
                start_go   = 1'b1;
                start_rate = capped_rate;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_flags_next  = {halves_reg != '0, taken_reg, led_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // A zero rate leaves the LED and the burst timer alone.
        if (start_go && start_rate != '0) begin
            half_period_next = start_half;
            countdown_next   = start_half;
            halves_next      = {start_rate, 1'b0};
            led_next         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            thr_reg         <= THR_RESET;
            max_rate_reg    <= RATE_RESET;
            prev_reg        <= '0;
            half_period_reg <= '0;
            countdown_reg   <= '0;
            halves_reg      <= '0;
            led_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            thr_reg         <= thr_next;
            max_rate_reg    <= max_rate_next;
            prev_reg        <= prev_next;
            half_period_reg <= half_period_next;
            countdown_reg   <= countdown_next;
            halves_reg      <= halves_next;
            led_reg         <= led_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        count_reg     <= count_next;
        radio_off_reg <= radio_off_next;
        taken_reg     <= taken_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        iter_reg      <= iter_next;
        m_flags_reg   <= m_flags_next;
    end

endmodule

`default_nettype wire
